### rtl/hmd_pkg.sv
// ============================================================================
// hmd_pkg
// Shared types and constants for the gray-level histogram mode block.
// ============================================================================
package hmd_pkg;

    localparam int LEVEL_BITS    = 8;
    localparam int COUNT_BITS    = 24;
    localparam int PIXEL_BITS    = 8;
    localparam int NUM_LEVELS    = 1 << LEVEL_BITS;
    localparam int DISTINCT_BITS = LEVEL_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Meaning of the action field of an input transfer.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_END   = 1'b1;

    typedef logic [LEVEL_BITS-1:0]    level_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [DISTINCT_BITS-1:0] distinct_t;

    typedef struct packed {
        logic                  action;
        logic [PIXEL_BITS-1:0] pixel;
    } pix_t;

    typedef struct packed {
        level_t    mode_level;
        count_t    mode_count;
        distinct_t distinct_levels;
    } res_t;

    // One write into the histogram memory.
    typedef struct packed {
        logic   en;
        level_t addr;
        count_t data;
    } mem_wr_t;

    // Controls from the sequencer to the scan unit.
    typedef struct packed {
        logic start;
        logic step;
        logic report;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_FLUSH,
        ST_REPORT
    } state_t;

endpackage

### rtl/hmd_ram.sv
// ============================================================================
// hmd_ram
// Generic single-write, single-read memory with a registered read port.
// A read at the address being written returns the old contents.
// ============================================================================
module hmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hmd_pixel.sv
// ============================================================================
// hmd_pixel
// Read-modify-write path that adds one pixel to its level's counter.
// The write of the previous cycle is forwarded when it hits the same level.
// ============================================================================
module hmd_pixel
    import hmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    issue,
    input  level_t  level,
    input  count_t  rdata,
    output mem_wr_t wr
);

    logic   s1_valid_reg;
    level_t s1_addr_reg;
    logic   fwd_valid_reg;
    level_t fwd_addr_reg;
    count_t fwd_data_reg;
    count_t cur;
    count_t upd;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = rdata;
        end
        // Counters saturate at their top value.
        upd = (cur == COUNT_MAX) ? cur : cur + count_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= level;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= upd;
    end

    assign wr.en   = s1_valid_reg;
    assign wr.addr = s1_addr_reg;
    assign wr.data = upd;

endmodule

### rtl/hmd_scan.sv
// ============================================================================
// hmd_scan
// Address counter for the sweep over all levels and the accumulator that
// tracks the mode and the number of distinct levels.
// ============================================================================
module hmd_scan
    import hmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_ctl_t ctl,
    input  count_t    rdata,
    output level_t    addr,
    output logic      last,
    output res_t      result
);

    level_t    addr_reg;
    logic      acc_en_reg;
    level_t    data_addr_reg;
    level_t    best_level_reg;
    count_t    best_count_reg;
    distinct_t distinct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                addr_reg <= '0;
            end
            else if (ctl.step)
            begin
                addr_reg <= addr_reg + level_t'(1);
            end
            acc_en_reg <= ctl.step && ctl.report;
        end
    end

    always_ff @(posedge clk)
    begin
        data_addr_reg <= addr_reg;
        if (ctl.start)
        begin
            best_level_reg <= '0;
            best_count_reg <= '0;
            distinct_reg   <= '0;
        end
        else if (acc_en_reg)
        begin
            if (rdata != '0)
            begin
                distinct_reg <= distinct_reg + distinct_t'(1);
            end
            // Strictly greater, so the lowest level keeps a tie.
            if (rdata > best_count_reg)
            begin
                best_count_reg <= rdata;
                best_level_reg <= data_addr_reg;
            end
        end
    end

    assign addr                   = addr_reg;
    assign last                   = (addr_reg == level_t'(NUM_LEVELS - 1));
    assign result.mode_level      = best_level_reg;
    assign result.mode_count      = best_count_reg;
    assign result.distinct_levels = distinct_reg;

endmodule

### rtl/histogram_mode_distinct.sv
// ============================================================================
// histogram_mode_distinct
// Gray-level histogram with mode and distinct-level report.
// ============================================================================
//
//  Channel | Signals                    | Direction | Content
//  --------+----------------------------+-----------+-----------------------------
//  pix     | pix_valid, pix_stall, pix  | in        | action and pixel gray level
//  res     | res_valid, res_stall, res  | out       | mode level, count, distinct
//
//  A pixel transfer is taken every cycle while pix_stall is low; its counter update
//  passes through the memory's registered read port, with the previous write forwarded.
//  An end-of-image transfer starts a sweep that reads all 256 counters, then a
//  flush state finishes the accumulation and a report state loads the result register.
//  After reset the block clears all 256 counters with pix_stall high.
//  The result waits in an output register while res_stall is high. The sweep
//  of a later image always runs; only its result load waits while that
//  register is still full and stalled, and pix_stall stays high until the load happens.
//
module histogram_mode_distinct
    import hmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    output logic pix_stall,
    input  pix_t pix,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    state_t    state_reg;
    state_t    state_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    res_t      res_reg;
    logic      load_res;

    logic      pix_take;
    logic      pixel_issue;
    level_t    pix_level;
    scan_ctl_t scan_ctl;
    level_t    scan_addr;
    logic      scan_last;
    res_t      scan_result;
    mem_wr_t   pix_wr;
    mem_wr_t   mem_wr;
    level_t    mem_raddr;
    count_t    mem_rdata;

    // The input side is open only while pixels are being counted.
    assign pix_stall   = (state_reg != ST_RUN);
    assign pix_take    = pix_valid && !pix_stall;
    assign pixel_issue = pix_take && (pix.action == ACT_PIXEL);
    assign pix_level   = level_t'(pix.pixel);

    // Sequencer: clearing pass, pixel counting, report sweep and hand-off.
    always_comb
    begin
        state_next      = state_reg;
        scan_ctl.start  = 1'b0;
        scan_ctl.step   = 1'b0;
        scan_ctl.report = 1'b0;
        load_res        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                scan_ctl.step = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pix_take && (pix.action == ACT_END))
                begin
                    scan_ctl.start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_ctl.step   = 1'b1;
                scan_ctl.report = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The last counter is folded into the accumulator here.
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    load_res   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // During the clearing pass and the report sweep, each counter is read
    // and zeroed in the same cycle; the memory returns the old value.
    always_comb
    begin
        if ((state_reg == ST_CLEAR) || (state_reg == ST_SCAN))
        begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = scan_addr;
            mem_wr.data = '0;
            mem_raddr   = scan_addr;
        end
        else
        begin
            mem_wr    = pix_wr;
            mem_raddr = pix_level;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= scan_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    hmd_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_LEVELS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hmd_pixel u_pixel (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (pixel_issue),
        .level (pix_level),
        .rdata (mem_rdata),
        .wr    (pix_wr)
    );

    hmd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .rdata  (mem_rdata),
        .addr   (scan_addr),
        .last   (scan_last),
        .result (scan_result)
    );

endmodule

### rtl/hmd_checker.sv
// ============================================================================
// hmd_checker
// Port-level checks for the histogram mode block, bound to the top level.
// ============================================================================
module hmd_checker
    import hmd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pix_valid,
    input logic pix_stall,
    input pix_t pix,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result payload changed while stalled");

    // An end-of-image transfer closes the input for the sweep.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && (pix.action == ACT_END) |=> pix_stall)
        else $error("input open right after end of image");

    // An empty image and only an empty image reports a zero count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.mode_count == '0) == (res.distinct_levels == '0)))
        else $error("mode count and distinct levels disagree on emptiness");

endmodule

bind histogram_mode_distinct hmd_checker u_hmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-level histogram mode testbench
// Drives pixel and end-of-image transfers into histogram_mode_distinct and
// checks every report against a histogram kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import hmd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    // The limit covers the worst case: every item waits its longest gap,
    // every report needs a full sweep plus its longest hold, and reset
    // is followed by a clearing pass.
    localparam int CYCLE_LIMIT  = 1000000;
    // A sweep of all levels plus the result register load, with margin.
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_WAIT     = 16;
    localparam int MAX_REPORTED = 10;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    pix_t pix;
    logic res_valid;
    logic res_stall;
    res_t res;

    histogram_mode_distinct dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Our own copy of the histogram store and the reports it must produce,
    // oldest first.
    count_t      level_hist [NUM_LEVELS];
    res_t        pending_reports [$];

    // Idle controls for the two sides; each test phase sets them.
    bit          src_gaps;
    bit          snk_gaps;

    int unsigned pixel_count;
    int unsigned image_count;
    int unsigned report_count;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned snk_hold;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d reports outstanding.",
                     cycle_count, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Update the histogram for one accepted transfer. An end-of-image
    // transfer scans the store from the lowest level upward; a level takes
    // over only with a strictly larger count, so ties go to the lowest level.
    task automatic apply_transfer(input pix_t item);
        level_t      lvl;
        res_t        rpt;
        int unsigned distinct;
        if (item.action == ACT_PIXEL)
        begin
            lvl = level_t'(item.pixel);
            if (level_hist[lvl] != COUNT_MAX)
            begin
                level_hist[lvl] = level_hist[lvl] + 1'b1;
            end
            pixel_count++;
        end
        else
        begin
            rpt      = '0;
            distinct = 0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                if (level_hist[i] != '0)
                begin
                    distinct++;
                end
                if (level_hist[i] > rpt.mode_count)
                begin
                    rpt.mode_count = level_hist[i];
                    rpt.mode_level = level_t'(i);
                end
                level_hist[i] = '0;
            end
            rpt.distinct_levels = distinct_t'(distinct);
            pending_reports.insert(pending_reports.size(), rpt);
            image_count++;
        end
    endtask

    // Present one item, idling first if the sender is in a gappy phase, and
    // hold it until the block takes it.
    task automatic send_item(input pix_t item);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= item;
        @(posedge clk);
        while (pix_stall)
        begin
            @(posedge clk);
        end
        apply_transfer(item);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] level);
        pix_t item;
        item.action = ACT_PIXEL;
        item.pixel  = level;
        send_item(item);
    endtask

    // The pixel field of an end-of-image transfer carries random junk, since
    // the block must ignore it.
    task automatic send_end();
        pix_t item;
        item.action = ACT_END;
        item.pixel  = PIXEL_BITS'($urandom);
        send_item(item);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Result side: check every accepted report, then decide how long the
    // next one is held off. The hold only counts down while a report waits.
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int unsigned hold;
        res_t        want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            snk_hold  <= 0;
        end
        else if (res_valid && !res_stall)
        begin
            report_count++;
            if (pending_reports.size() == 0)
            begin
                note_failure($sformatf("unexpected report level=%0d count=%0d distinct=%0d",
                                       res.mode_level, res.mode_count,
                                       res.distinct_levels));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (res.mode_level !== want.mode_level ||
                    res.mode_count !== want.mode_count ||
                    res.distinct_levels !== want.distinct_levels)
                begin
                    note_failure({
                        $sformatf("report %0d: expected level=%0d count=%0d distinct=%0d",
                                  report_count, want.mode_level, want.mode_count,
                                  want.distinct_levels),
                        $sformatf(", got level=%0d count=%0d distinct=%0d",
                                  res.mode_level, res.mode_count,
                                  res.distinct_levels)});
                end
            end
            hold = snk_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            snk_hold  <= hold;
            res_stall <= (hold != 0);
        end
        else if (res_valid && res_stall)
        begin
            snk_hold  <= snk_hold - 1;
            res_stall <= (snk_hold > 1);
        end
    end

    // An image with nothing in it reports all zeros, also twice in a row.
    task automatic test_empty_image();
        send_end();
        send_end();
    endtask

    // Lowest and highest gray levels; equal counts at both ends go to level 0.
    task automatic test_level_extremes();
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_end();
        send_pixel(8'd255);
        send_end();
        send_pixel(8'd0);
        send_end();
    endtask

    // A tie must go to the lower level even when the higher one arrives first.
    // The run of one level back to back exercises the update forwarding.
    task automatic test_tie_goes_low();
        send_pixel(8'd200);
        send_pixel(8'd7);
        send_pixel(8'd200);
        send_pixel(8'd7);
        send_pixel(8'd100);
        send_end();
        send_pixel(8'd9);
        send_pixel(8'd9);
        send_pixel(8'd9);
        send_end();
    endtask

    // Every level present: distinct reaches its largest possible value of 256. The first
    // image is an all-way tie, the second has one level counted twice.
    task automatic test_full_range();
        logic [PIXEL_BITS-1:0] start;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            send_pixel(i[PIXEL_BITS-1:0]);
        end
        send_end();
        start = PIXEL_BITS'($urandom);
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            send_pixel(start + i[PIXEL_BITS-1:0]);
        end
        send_pixel(PIXEL_BITS'($urandom));
        send_end();
    endtask

    // Gray levels for random images lean toward the two extremes.
    function automatic logic [PIXEL_BITS-1:0] pick_level();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return PIXEL_BITS'($urandom);
    endfunction

    // One random image closed by an end-of-image transfer: sometimes empty,
    // sometimes a built tie, most often a few repeating levels, else pure noise.
    task automatic send_random_image();
        int unsigned           kind;
        int unsigned           len;
        int unsigned           width;
        logic [PIXEL_BITS-1:0] palette [4];
        logic [PIXEL_BITS-1:0] lvl_a;
        logic [PIXEL_BITS-1:0] lvl_b;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            len = 0;
        end
        else if (kind <= 2)
        begin
            lvl_a = pick_level();
            lvl_b = pick_level();
            if (lvl_b == lvl_a)
            begin
                lvl_b = lvl_a + 1'b1;
            end
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_pixel(lvl_a);
                    send_pixel(lvl_b);
                end
                else
                begin
                    send_pixel(lvl_b);
                    send_pixel(lvl_a);
                end
            end
        end
        else if (kind <= 6)
        begin
            width = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++)
            begin
                palette[i] = pick_level();
            end
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                send_pixel(palette[$urandom_range(0, width - 1)]);
            end
        end
        else
        begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                send_pixel(PIXEL_BITS'($urandom));
            end
        end
        send_end();
    endtask

    task automatic test_random_images(input int unsigned items, input bit src_idle,
                                      input bit snk_idle);
        int unsigned goal;
        src_gaps = src_idle;
        snk_gaps = snk_idle;
        goal     = pixel_count + image_count + items;
        while (pixel_count + image_count < goal)
        begin
            send_random_image();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix       <= '0;
        src_gaps     = 1'b0;
        snk_gaps     = 1'b0;
        pixel_count  = 0;
        image_count  = 0;
        report_count = 0;
        fail_count   = 0;
        cycle_count  = 0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            level_hist[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases run back to back on the pixel side so that repeated
        // levels hit the forwarding path, while reports get held off.
        snk_gaps = 1'b1;
        test_empty_image();
        test_level_extremes();
        test_tie_goes_low();

        src_gaps = 1'b1;
        test_full_range();

        test_random_images(150, 1'b1, 1'b1);
        test_random_images(150, 1'b0, 1'b0);
        test_random_images(150, 1'b1, 1'b0);
        test_random_images(150, 1'b0, 1'b1);
        pix_valid <= 1'b0;

        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        // Any stray report would show up within one more sweep.
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += pending_reports.size();

        $display("Sent %0d pixels in %0d images and checked %0d reports, %0d failures.",
                 pixel_count, image_count, report_count, fail_count);
        $display("Images covered empty, tied, extreme-level, noisy and full-range cases.");
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### histogram_mode_distinct.f
rtl/hmd_pkg.sv
rtl/hmd_ram.sv
rtl/hmd_pixel.sv
rtl/hmd_scan.sv
rtl/histogram_mode_distinct.sv
rtl/hmd_checker.sv
bench/tb.sv
